// File: hw/rtl/mrpt_pkg.sv
// Shared constants and types of the Miller-Rabin prime tester.
`default_nettype none

package mrpt_pkg;

   // Width of the tested value.
   localparam int WIDTH = 64;

   // Multiplier bit count: wide enough for both the tested value and the bases.
   localparam int MUL_BITS = (WIDTH > 32) ? WIDTH : 32;

   // Witness bases, exact for every value below 2^64. They are listed from the
   // last to the first, so that base k sits at bits k * BASE_W upward.
   localparam int BASE_W    = 32;
   localparam int NUM_BASES = 7;
   localparam int KW        = $clog2(NUM_BASES);
   localparam logic [NUM_BASES*BASE_W-1:0] BASES = {
      32'd1795265022, 32'd9780504, 32'd450775, 32'd28178, 32'd9375, 32'd325, 32'd2
   };

   // Width of the power-of-two count of n - 1 and of the squaring counter.
   localparam int SW = $clog2(WIDTH);

   // Outcome of the small-number screen.
   typedef struct packed {
      logic done;
      logic settled;
      logic is_prime;
   } screen_type;

endpackage

`default_nettype wire

// File: hw/rtl/mrpt_screen.sv
// Bit-serial small-number screen: value below two, even value or multiple of three.
`default_nettype none

module mrpt_screen import mrpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] number,
   output screen_type       verdict
);

   logic             active_ff, active_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] shift_ff, shift_in;
   logic [1:0]       rem_ff, rem_in;
   logic [1:0]       high_ff, high_in;
   screen_type       verdict_ff, verdict_in;
   logic             bit_now;
   logic [1:0]       rem_next;

   // Remainder modulo three after appending one bit: {r, b} equals 2r + b.
   function automatic logic [1:0] rem3_step(input logic [1:0] r, input logic b);
      logic [1:0] res;
      case ({r, b})
         3'd0:    res = 2'd0;
         3'd1:    res = 2'd1;
         3'd2:    res = 2'd2;
         3'd3:    res = 2'd0;
         3'd4:    res = 2'd1;
         3'd5:    res = 2'd2;
         default: res = 2'd0;
      endcase
      return res;
   endfunction

   assign bit_now  = shift_ff[WIDTH-1];
   assign rem_next = rem3_step(rem_ff, bit_now);

   // The value is scanned most significant bit first. The upper bits are kept as a
   // value that saturates at two, which is enough to tell zero, one and more apart.
   always_comb begin
      active_in  = active_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      high_in    = high_ff;
      verdict_in = '0;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = SW'(WIDTH - 1);
         shift_in  = number;
         rem_in    = 2'd0;
         high_in   = 2'd0;
      end else if (active_ff) begin
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         rem_in   = rem_next;
         cnt_in   = cnt_ff - SW'(1);
         if (cnt_ff != '0) begin
            high_in = (high_ff != 2'd0) ? 2'd2 : {1'b0, bit_now};
         end else begin
            // Last bit: the value is settled unless it is odd, at least five
            // and not a multiple of three. Only two and three are prime here.
            active_in          = 1'b0;
            verdict_in.done    = 1'b1;
            verdict_in.settled = (high_ff == 2'd0) || !bit_now || (rem_next == 2'd0);
            verdict_in.is_prime = (high_ff == 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         verdict_ff <= '0;
      end else begin
         active_ff  <= active_in;
         verdict_ff <= verdict_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      high_ff  <= high_in;
   end

   assign verdict = verdict_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mrpt_modmul.sv
// Bit-serial shift-add modular multiplier: one multiplier bit per cycle.
`default_nettype none

module mrpt_modmul import mrpt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDTH-1:0]    x,
   input  logic [MUL_BITS-1:0] y,
   input  logic [WIDTH-1:0]    m,
   output logic                done,
   output logic [WIDTH-1:0]    result
);

   localparam int MCW = $clog2(MUL_BITS);

   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [MCW-1:0]      cnt_ff, cnt_in;
   logic [MUL_BITS-1:0] y_ff, y_in;
   logic [WIDTH-1:0]    x_ff, x_in;
   logic [WIDTH-1:0]    m_ff, m_in;
   logic [WIDTH:0]      m2_ff, m2_in;
   logic [WIDTH-1:0]    r_ff, r_in;
   logic [WIDTH+1:0]    sum;
   logic [WIDTH+1:0]    sub_one;
   logic [WIDTH+1:0]    sub_two;
   logic [WIDTH-1:0]    r_next;

   // One step: r = (2r + bit * x) mod m. The sum stays below 3m, so a choice
   // between the sum, sum - m and sum - 2m reduces it exactly.
   always_comb begin
      sum     = {1'b0, r_ff, 1'b0} + (y_ff[MUL_BITS-1] ? {2'b00, x_ff} : '0);
      sub_one = sum - {2'b00, m_ff};
      sub_two = sum - {1'b0, m2_ff};
      if (sum >= {1'b0, m2_ff}) begin
         r_next = sub_two[WIDTH-1:0];
      end else if (sum >= {2'b00, m_ff}) begin
         r_next = sub_one[WIDTH-1:0];
      end else begin
         r_next = sum[WIDTH-1:0];
      end
   end

   // Operands are captured on start; the multiplier bits then leave the top of
   // the shift register one per cycle.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      m_in      = m_ff;
      m2_in     = m2_ff;
      r_in      = r_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = MCW'(MUL_BITS - 1);
         y_in      = y;
         x_in      = x;
         m_in      = m;
         m2_in     = {m, 1'b0};
         r_in      = '0;
      end else if (active_ff) begin
         r_in   = r_next;
         y_in   = {y_ff[MUL_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - MCW'(1);
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      y_ff   <= y_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
      m2_ff  <= m2_in;
      r_ff   <= r_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

`default_nettype wire

// File: hw/rtl/miller_rabin_prime_test.sv
// Top level of the deterministic Miller-Rabin prime tester with its sequencer.
//
//   Channel   Ports                      Transfer
//   request   start, busy, req_number    start high while busy is low
//   response  rsp_valid, rsp_is_prime    one cycle strobe, always taken
//
// One number is tested at a time; busy stays high from the transfer until the
// result strobe. Small values are settled by the bit-serial screen. Other values
// run through up to seven bases, each needing at most about 2 * WIDTH modular
// products in the single shift-add multiplier.
// Reset is synchronous and clears the sequencer; the receiver cannot stall.
`default_nettype none

module miller_rabin_prime_test import mrpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_number,
   output logic        rsp_valid,
   output logic        rsp_is_prime
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCREEN,
      S_SPLIT,
      S_BASE,
      S_REDUCE,
      S_POW,
      S_POW_ACC,
      S_POW_NEXT,
      S_POW_SQ,
      S_EVAL,
      S_SQ,
      S_SQ_EVAL
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_ACC,
      OP_SQ_B,
      OP_SQ_P
   } mul_op_type;

   state_type           state_ff;
   mul_op_type          op_ff;
   logic                mul_start_ff;
   logic                rsp_valid_ff;
   logic                rsp_is_prime_ff;
   logic [WIDTH-1:0]    n_ff;
   logic [WIDTH-1:0]    nm1_ff;
   logic [WIDTH-1:0]    d_ff;
   logic [WIDTH-1:0]    e_ff;
   logic [WIDTH-1:0]    acc_ff;
   logic [WIDTH-1:0]    b_ff;
   logic [SW-1:0]       s_ff;
   logic [SW-1:0]       i_ff;
   logic [KW-1:0]       k_ff;

   logic                accept;
   logic                last_base;
   screen_type          verdict;
   logic                mul_done;
   logic [WIDTH-1:0]    mul_result;
   logic [WIDTH-1:0]    mul_x;
   logic [MUL_BITS-1:0] mul_y;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign last_base = (k_ff == KW'(NUM_BASES - 1));

   // Small-number screen, started on the request transfer.
   mrpt_screen u_screen (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .number  (req_number[WIDTH-1:0]),
      .verdict (verdict)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      case (op_ff)
         OP_REDUCE: begin
            mul_x = WIDTH'(1);
            mul_y = MUL_BITS'(BASES[int'(k_ff) * BASE_W +: BASE_W]);
         end
         OP_ACC: begin
            mul_x = b_ff;
            mul_y = MUL_BITS'(acc_ff);
         end
         OP_SQ_B: begin
            mul_x = b_ff;
            mul_y = MUL_BITS'(b_ff);
         end
         OP_SQ_P: begin
            mul_x = acc_ff;
            mul_y = MUL_BITS'(acc_ff);
         end
         default: begin
            mul_x = acc_ff;
            mul_y = MUL_BITS'(acc_ff);
         end
      endcase
   end

   mrpt_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_ff),
      .x      (mul_x),
      .y      (mul_y),
      .m      (n_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   // Sequencer: screen, split n - 1, then for each base reduce it, raise it to
   // the odd part by right-to-left exponentiation and square up to s - 1 times.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mul_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_is_prime_ff <= 1'b0;
         op_ff           <= OP_REDUCE;
      end else begin
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  n_ff     <= req_number[WIDTH-1:0];
                  state_ff <= S_SCREEN;
               end
            end
            S_SCREEN: begin
               if (verdict.done) begin
                  if (verdict.settled) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_is_prime_ff <= verdict.is_prime;
                     state_ff        <= S_IDLE;
                  end else begin
                     nm1_ff   <= n_ff - WIDTH'(1);
                     d_ff     <= n_ff - WIDTH'(1);
                     s_ff     <= '0;
                     state_ff <= S_SPLIT;
                  end
               end
            end
            S_SPLIT: begin
               if (!d_ff[0]) begin
                  d_ff <= {1'b0, d_ff[WIDTH-1:1]};
                  s_ff <= s_ff + SW'(1);
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               op_ff        <= OP_REDUCE;
               mul_start_ff <= 1'b1;
               state_ff     <= S_REDUCE;
            end
            S_REDUCE: begin
               if (mul_done) begin
                  if (mul_result == '0) begin
                     // A base that is a multiple of n counts as passed.
                     if (last_base) begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_is_prime_ff <= 1'b1;
                        state_ff        <= S_IDLE;
                     end else begin
                        k_ff     <= k_ff + KW'(1);
                        state_ff <= S_BASE;
                     end
                  end else begin
                     b_ff     <= mul_result;
                     acc_ff   <= WIDTH'(1);
                     e_ff     <= d_ff;
                     state_ff <= S_POW;
                  end
               end
            end
            S_POW: begin
               if (e_ff[0]) begin
                  op_ff        <= OP_ACC;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_POW_ACC;
               end else begin
                  state_ff <= S_POW_NEXT;
               end
            end
            S_POW_ACC: begin
               if (mul_done) begin
                  acc_ff   <= mul_result;
                  state_ff <= S_POW_NEXT;
               end
            end
            S_POW_NEXT: begin
               e_ff <= {1'b0, e_ff[WIDTH-1:1]};
               if (e_ff[WIDTH-1:1] == '0) begin
                  state_ff <= S_EVAL;
               end else begin
                  op_ff        <= OP_SQ_B;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_POW_SQ;
               end
            end
            S_POW_SQ: begin
               if (mul_done) begin
                  b_ff     <= mul_result;
                  state_ff <= S_POW;
               end
            end
            S_EVAL: begin
               if ((acc_ff == WIDTH'(1)) || (acc_ff == nm1_ff)) begin
                  if (last_base) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_is_prime_ff <= 1'b1;
                     state_ff        <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + KW'(1);
                     state_ff <= S_BASE;
                  end
               end else if (s_ff > SW'(1)) begin
                  i_ff         <= SW'(1);
                  op_ff        <= OP_SQ_P;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQ;
               end else begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_is_prime_ff <= 1'b0;
                  state_ff        <= S_IDLE;
               end
            end
            S_SQ: begin
               if (mul_done) begin
                  acc_ff   <= mul_result;
                  i_ff     <= i_ff + SW'(1);
                  state_ff <= S_SQ_EVAL;
               end
            end
            S_SQ_EVAL: begin
               if (acc_ff == nm1_ff) begin
                  if (last_base) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_is_prime_ff <= 1'b1;
                     state_ff        <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + KW'(1);
                     state_ff <= S_BASE;
                  end
               end else if ((acc_ff == WIDTH'(1)) || (i_ff >= s_ff)) begin
                  // A non-trivial square root of one, or no squaring left: composite.
                  rsp_valid_ff    <= 1'b1;
                  rsp_is_prime_ff <= 1'b0;
                  state_ff        <= S_IDLE;
               end else begin
                  op_ff        <= OP_SQ_P;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_SQ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

`default_nettype wire
